// ===== design/ucd_pkg.sv =====
package ucd_pkg;

    // Field widths
    localparam int TS_W   = 32;
    localparam int DAYS_W = 16;
    localparam int JD_W   = 22;
    localparam int YR_W   = 13;
    localparam int DD_W   = 10;

    // Reciprocals for exact division by a constant: floor(x * M / 2**K) == x / d
    // for every x below 2**N, with K = N + clog2(d) and M = ceil(2**K / d).
    // t/60 = (t>>2)/15 on 30 bits
    localparam int              SEC_K = 34;
    localparam logic [30:0]     M_SEC = 31'(((64'd1 << SEC_K) + 64'd14) / 64'd15);
    // q1/60 = (q1>>2)/15 on 25 bits
    localparam int              MIN_K = 29;
    localparam logic [25:0]     M_MIN = 26'(((64'd1 << MIN_K) + 64'd14) / 64'd15);
    // q2/24 = (q2>>3)/3 on 18 bits
    localparam int              HR_K  = 20;
    localparam logic [18:0]     M_HR  = 19'(((64'd1 << HR_K) + 64'd2) / 64'd3);
    // (days+3)/7 on 17 bits
    localparam int              WK_K  = 20;
    localparam logic [17:0]     M_WK  = 18'(((64'd1 << WK_K) + 64'd6) / 64'd7);
    // (20b-2442)/7305 on 26 bits
    localparam int              YR_K  = 39;
    localparam logic [26:0]     M_YR  = 27'(((64'd1 << YR_K) + 64'd7304) / 64'd7305);

    // Julian-day constants
    localparam logic [18:0]     ERA_BIAS      = 19'd102032;
    localparam logic [18:0]     ERA_LIMIT2    = 19'd292194;  // two 400-year eras
    localparam logic [JD_W-1:0] EPOCH_JD      = 22'd2442113;
    localparam logic [25:0]     YR_BIAS       = 26'd2442;
    localparam logic [JD_W-1:0] DAYS_PER_YEAR = 22'd365;
    localparam logic [YR_W-1:0] YEAR_OFF_LO   = 13'd6616;    // 4716 + 1900
    localparam logic [YR_W-1:0] YEAR_OFF_HI   = 13'd6615;    // 4715 + 1900
    localparam logic [3:0]      MONTH_WRAP    = 4'd13;
    localparam logic [7:0]      YS_CENTURY    = 8'd200;      // 2100 is not leap

    // Smallest dd that reaches month index k+1: ceil(30.601 * (k+1))
    localparam logic [DD_W-1:0] MONTH_THRESH [15] = '{
        10'd31,  10'd62,  10'd92,  10'd123, 10'd154, 10'd184, 10'd215, 10'd245,
        10'd276, 10'd307, 10'd337, 10'd368, 10'd398, 10'd429, 10'd460
    };

    // Days before month index e: 30e + floor(0.601e)
    localparam logic [DD_W-1:0] MONTH_BASE [16] = '{
        10'd0,   10'd30,  10'd61,  10'd91,  10'd122, 10'd153, 10'd183, 10'd214,
        10'd244, 10'd275, 10'd306, 10'd336, 10'd367, 10'd397, 10'd428, 10'd459
    };

    // Cumulative days before each month, common year
    localparam logic [8:0] DAYS_BEFORE [12] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // Time-of-day fields plus the zero-timestamp flag
    typedef struct packed {
        logic       zero;
        logic [5:0] sec;
        logic [5:0] minute;
        logic [4:0] hr;
    } t_hms;

    typedef struct packed {
        logic              vld;
        t_hms              hms;
        logic [DAYS_W-1:0] days;
    } t_tod;

    typedef struct packed {
        logic       vld;
        t_hms       hms;
        logic [2:0] wday;
        logic [7:0] ys;
        logic [3:0] month;
        logic [4:0] dom;
    } t_date;

    typedef struct packed {
        logic       vld;
        logic       valid_res;
        logic [5:0] sec;
        logic [5:0] minute;
        logic [4:0] hr;
        logic [7:0] ys;
        logic [3:0] month;
        logic [4:0] dom;
        logic [2:0] wday;
        logic [8:0] doy;
    } t_cal;

    // Day-of-year base with the month clamped to 1..12
    function automatic logic [8:0] doy_base(input logic leap, input logic [3:0] month);
        logic [3:0] mi;
        mi = month;
        if (mi < 4'd1) begin
            mi = 4'd1;
        end
        if (mi > 4'd12) begin
            mi = 4'd12;
        end
        return DAYS_BEFORE[4'(mi - 4'd1)] + 9'((leap && (mi > 4'd2)) ? 1 : 0);
    endfunction

endpackage

// ===== design/ucd_time_split.sv =====
module ucd_time_split import ucd_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [TS_W-1:0] i_timestamp,
    output t_tod            o_tod
);

    logic [3:0]  r_vld;

    logic [60:0] w_p1;
    logic [50:0] w_p2;
    logic [36:0] w_p3;

    // stage 1: t / 60
    logic [5:0]      r1_ts;
    logic [26:0]     r1_q1;
    logic            r1_zero;

    // stage 2: seconds, q1 / 60
    logic [5:0]  r2_sec;
    logic [5:0]  r2_q1lo;
    logic [20:0] r2_q2;
    logic        r2_zero;

    // stage 3: minutes, q2 / 24
    logic [5:0]        r3_sec;
    logic [5:0]        r3_min;
    logic [4:0]        r3_q2lo;
    logic [DAYS_W-1:0] r3_q3;
    logic              r3_zero;

    // stage 4: hours, day count
    t_hms              r4_hms;
    logic [DAYS_W-1:0] r4_days;

    assign w_p1 = 61'(i_timestamp[TS_W-1:2]) * 61'(M_SEC);
    assign w_p2 = 51'(r1_q1[26:2]) * 51'(M_MIN);
    assign w_p3 = 37'(r2_q2[20:3]) * 37'(M_HR);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ts   <= i_timestamp[5:0];
            r1_q1   <= w_p1[60:34];
            r1_zero <= (i_timestamp == '0);

            // t - 60*q1 == t + 4*q1 (mod 64)
            r2_sec  <= r1_ts + {r1_q1[3:0], 2'b00};
            r2_q1lo <= r1_q1[5:0];
            r2_q2   <= w_p2[49:29];
            r2_zero <= r1_zero;

            r3_sec  <= r2_sec;
            r3_min  <= r2_q1lo + {r2_q2[3:0], 2'b00};
            r3_q2lo <= r2_q2[4:0];
            r3_q3   <= w_p3[35:20];
            r3_zero <= r2_zero;

            // q2 - 24*q3 == q2 + 8*q3 (mod 32)
            r4_hms.zero   <= r3_zero;
            r4_hms.sec    <= r3_sec;
            r4_hms.minute <= r3_min;
            r4_hms.hr     <= r3_q2lo + {r3_q3[1:0], 3'b000};
            r4_days       <= r3_q3;
        end
    end

    always_comb begin
        o_tod.vld  = r_vld[3];
        o_tod.hms  = r4_hms;
        o_tod.days = r4_days;
    end

    a_tod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r4_hms.sec < 6'd60) && (r4_hms.minute < 6'd60) && (r4_hms.hr < 5'd24))
        else $error("time-of-day split out of range");

endmodule

// ===== design/ucd_date_core.sv =====
module ucd_date_core import ucd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_tod  i_tod,
    output t_date o_date
);

    logic [4:0] r_vld;

    // stage 1 comb: era adjust, day number, weekday quotient
    logic [18:0]     w_era;
    logic [4:0]      w_adj;
    logic [JD_W-1:0] w_b;
    logic [16:0]     w_w;
    logic [34:0]     w_pw;

    // stage 2 comb: year estimate
    logic [25:0] w_n;
    logic [52:0] w_pc;

    // stage 3/4 comb
    logic [DD_W-1:0] w_dd;
    logic [3:0]      n_e;

    t_hms            r1_hms;
    logic [JD_W-1:0] r1_b;
    logic [2:0]      r1_w3;
    logic [2:0]      r1_wq3;

    t_hms            r2_hms;
    logic [JD_W-1:0] r2_b;
    logic [YR_W-1:0] r2_c;
    logic [2:0]      r2_wday;

    t_hms            r3_hms;
    logic [DD_W-1:0] r3_dd;
    logic [YR_W-1:0] r3_c;
    logic [2:0]      r3_wday;

    t_hms            r4_hms;
    logic [DD_W-1:0] r4_dd;
    logic [YR_W-1:0] r4_c;
    logic [3:0]      r4_e;
    logic [2:0]      r4_wday;

    t_hms       r5_hms;
    logic [2:0] r5_wday;
    logic [7:0] r5_ys;
    logic [3:0] r5_month;
    logic [4:0] r5_dom;

    assign w_era = 19'({i_tod.days, 2'b00}) + ERA_BIAS;
    assign w_adj = (w_era >= ERA_LIMIT2) ? 5'd13 : 5'd12;
    assign w_b   = 22'(i_tod.days) + EPOCH_JD + 22'(w_adj);
    assign w_w   = 17'(i_tod.days) + 17'd3;
    assign w_pw  = 35'(w_w) * 35'(M_WK);

    assign w_n  = 26'({r1_b, 4'b0000}) + 26'({r1_b, 2'b00}) - YR_BIAS;
    assign w_pc = 53'(w_n) * 53'(M_YR);

    assign w_dd = DD_W'(r2_b - 22'(r2_c) * DAYS_PER_YEAR - 22'(r2_c[YR_W-1:2]));

    // month index: count of thresholds reached
    always_comb begin
        n_e = '0;
        for (int k = 0; k < 15; k++) begin
            n_e = n_e + 4'(r3_dd >= MONTH_THRESH[k]);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_tod.vld};
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_hms <= i_tod.hms;
            r1_b   <= w_b;
            r1_w3  <= w_w[2:0];
            r1_wq3 <= w_pw[22:20];

            // w - 7*wq == w + wq (mod 8), then Monday-based 1..7
            r2_hms  <= r1_hms;
            r2_b    <= r1_b;
            r2_c    <= w_pc[51:39];
            r2_wday <= 3'(r1_w3 + r1_wq3) + 3'd1;

            r3_hms  <= r2_hms;
            r3_dd   <= w_dd;
            r3_c    <= r2_c;
            r3_wday <= r2_wday;

            r4_hms  <= r3_hms;
            r4_dd   <= r3_dd;
            r4_c    <= r3_c;
            r4_e    <= n_e;
            r4_wday <= r3_wday;

            // January and February belong to the following year
            r5_hms  <= r4_hms;
            r5_wday <= r4_wday;
            r5_dom  <= 5'(r4_dd - MONTH_BASE[r4_e]);
            if (r4_e <= MONTH_WRAP) begin
                r5_month <= r4_e - 4'd1;
                r5_ys    <= 8'(r4_c - YEAR_OFF_LO);
            end else begin
                r5_month <= r4_e - MONTH_WRAP;
                r5_ys    <= 8'(r4_c - YEAR_OFF_HI);
            end
        end
    end

    always_comb begin
        o_date.vld   = r_vld[4];
        o_date.hms   = r5_hms;
        o_date.wday  = r5_wday;
        o_date.ys    = r5_ys;
        o_date.month = r5_month;
        o_date.dom   = r5_dom;
    end

    a_month_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && !r4_hms.zero) |-> (r4_e >= 4'd4) && (r4_e <= 4'd15))
        else $error("month index outside March..February");

endmodule

// ===== design/ucd_day_count.sv =====
module ucd_day_count import ucd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_date i_date,
    output t_cal  o_cal
);

    logic       w_leap;
    logic [8:0] w_doy;
    t_cal       r_cal;

    // year offset from 1900 keeps the mod-4 test; only 2100 is a skipped century
    assign w_leap = (i_date.ys[1:0] == 2'b00) && (i_date.ys != YS_CENTURY);
    assign w_doy  = doy_base(w_leap, i_date.month) + 9'(i_date.dom);

    // output register, zero timestamp clears every field but vld
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.vld <= 1'b0;
        end else if (i_en) begin
            r_cal.vld <= i_date.vld;
            if (i_date.hms.zero) begin
                r_cal.valid_res <= 1'b0;
                r_cal.sec       <= '0;
                r_cal.minute    <= '0;
                r_cal.hr        <= '0;
                r_cal.ys        <= '0;
                r_cal.month     <= '0;
                r_cal.dom       <= '0;
                r_cal.wday      <= '0;
                r_cal.doy       <= '0;
            end else begin
                r_cal.valid_res <= 1'b1;
                r_cal.sec       <= i_date.hms.sec;
                r_cal.minute    <= i_date.hms.minute;
                r_cal.hr        <= i_date.hms.hr;
                r_cal.ys        <= i_date.ys;
                r_cal.month     <= i_date.month;
                r_cal.dom       <= i_date.dom;
                r_cal.wday      <= i_date.wday;
                r_cal.doy       <= w_doy;
            end
        end
    end

    assign o_cal = r_cal;

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cal.vld && r_cal.valid_res) |->
            (r_cal.month >= 4'd1) && (r_cal.month <= 4'd12) &&
            (r_cal.dom >= 5'd1) && (r_cal.wday >= 3'd1) &&
            (r_cal.doy >= 9'd1) && (r_cal.doy <= 9'd366))
        else $error("converted date out of range");

    a_zero_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cal.vld && !r_cal.valid_res) |->
            (r_cal.month == 4'd0) && (r_cal.doy == 9'd0) && (r_cal.wday == 3'd0))
        else $error("zero timestamp beat carries data");

    a_doy_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cal.vld && r_cal.valid_res && (r_cal.month == 4'd1)) |->
            (r_cal.doy == 9'(r_cal.dom)))
        else $error("January day of year differs from day of month");

endmodule

// ===== design/unix_time_to_calendar_date_unit.sv =====
// Converts an unsigned 32-bit Unix timestamp (seconds since 1970-01-01 UTC)
// into the broken-down UTC date: second, minute, hour, year minus 1900, month
// 1..12, day of month, weekday (1 Monday .. 7 Sunday) and day of year. A
// timestamp of zero comes out with valid_res low and every other field zero.
// The unit is a 10-stage pipeline: four stages split off seconds, minutes and
// hours by reciprocal multiplication, five stages run the Julian-day date
// arithmetic, and one stage adds the day-of-year lookup into the output
// register. One beat enters per cycle while the pipeline is not stalled. A
// stall on the output holds the whole pipeline, and o_stall is high exactly
// when a finished result waits and i_stall is high.
module unix_time_to_calendar_date_unit import ucd_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [TS_W-1:0] i_timestamp,
    output logic            o_valid,
    input  logic            i_stall,
    output logic            o_valid_res,
    output logic [5:0]      o_second,
    output logic [5:0]      o_minute,
    output logic [4:0]      o_hour,
    output logic [7:0]      o_year_since_1900,
    output logic [3:0]      o_month,
    output logic [4:0]      o_day_of_month,
    output logic [2:0]      o_weekday,
    output logic [8:0]      o_day_of_year
);

    logic  w_en;
    t_tod  w_tod;
    t_date w_date;
    t_cal  w_cal;

    // pipeline advances unless a finished beat is held
    assign o_stall = w_cal.vld & i_stall;
    assign w_en    = ~o_stall;

    ucd_time_split u_time_split (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_vld       (i_valid),
        .i_timestamp (i_timestamp),
        .o_tod       (w_tod)
    );

    ucd_date_core u_date_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tod   (w_tod),
        .o_date  (w_date)
    );

    ucd_day_count u_day_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_date  (w_date),
        .o_cal   (w_cal)
    );

    assign o_valid           = w_cal.vld;
    assign o_valid_res       = w_cal.valid_res;
    assign o_second          = w_cal.sec;
    assign o_minute          = w_cal.minute;
    assign o_hour            = w_cal.hr;
    assign o_year_since_1900 = w_cal.ys;
    assign o_month           = w_cal.month;
    assign o_day_of_month    = w_cal.dom;
    assign o_weekday         = w_cal.wday;
    assign o_day_of_year     = w_cal.doy;

endmodule

// ===== dv/ucd_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the date unit, predicts each result from the
// accepted timestamp and compares it with what comes out, in order.
module ucd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_timestamp,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_valid_res,
    input  logic [5:0]  i_second,
    input  logic [5:0]  i_minute,
    input  logic [4:0]  i_hour,
    input  logic [7:0]  i_year_since_1900,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day_of_month,
    input  logic [2:0]  i_weekday,
    input  logic [8:0]  i_day_of_year,
    output int          o_err_count,
    output int          o_pending
);

    typedef struct packed {
        logic       valid_res;
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] mday;
        logic [2:0] wday;
        logic [8:0] yday;
    } cal_date_t;

    cal_date_t expected_dates [$];
    int        mismatch_count = 0;
    int        pending_count  = 0;

    assign o_err_count = mismatch_count;
    assign o_pending   = pending_count;

    // Broken-down UTC date of a timestamp, Julian-day style
    function automatic cal_date_t convert_unix_time(input logic [31:0] stamp);
        longint unsigned t, days, a, b, c, dd, e, f;
        longint unsigned y, m, cent, yoc, h, month_start;
        logic            leap;
        cal_date_t       r;
        r = '0;
        if (stamp == 32'd0) begin
            return r;
        end
        t = stamp;
        r.valid_res = 1'b1;
        r.second    = 6'(t % 60);
        t           = t / 60;
        r.minute    = 6'(t % 60);
        t           = t / 60;
        r.hour      = 5'(t % 24);
        days        = t / 24;

        a  = (4 * days + 102032) / 146097 + 15;
        b  = days + 2442113 + a - a / 4;
        c  = (20 * b - 2442) / 7305;
        dd = b - 365 * c - c / 4;
        e  = dd * 1000 / 30601;
        f  = dd - e * 30 - e * 601 / 1000;
        // months 14 and 15 belong to the next calendar year
        if (e <= 13) begin
            c = c - 4716;
            e = e - 1;
        end else begin
            c = c - 4715;
            e = e - 13;
        end
        r.year  = 8'(c - 1900);
        r.month = 4'(e);
        r.mday  = 5'(f);

        // Zeller: Jan/Feb count as months 13/14 of the year before
        y = c;
        m = e;
        if (m <= 2) begin
            m = m + 12;
            y = y - 1;
        end
        cent   = y / 100;
        yoc    = y % 100;
        h      = f + (26 * (m + 1)) / 10 + yoc + yoc / 4 + 5 * cent + cent / 4;
        r.wday = 3'((h + 5) % 7 + 1);

        // Gregorian leap rule, month clamped to 1..12
        leap = (c % 400 == 0) || ((c % 4 == 0) && (c % 100 != 0));
        if (e < 1) begin
            e = 1;
        end
        if (e > 12) begin
            e = 12;
        end
        case (e)
            1:       month_start = 0;
            2:       month_start = 31;
            3:       month_start = 59;
            4:       month_start = 90;
            5:       month_start = 120;
            6:       month_start = 151;
            7:       month_start = 181;
            8:       month_start = 212;
            9:       month_start = 243;
            10:      month_start = 273;
            11:      month_start = 304;
            default: month_start = 334;
        endcase
        if (leap && e > 2) begin
            month_start = month_start + 1;
        end
        r.yday = 9'(month_start + f);
        return r;
    endfunction

    function automatic string date_text(input cal_date_t d);
        return $sformatf("v=%0d %0d:%0d:%0d y=%0d m=%0d d=%0d wd=%0d yd=%0d",
                         d.valid_res, d.hour, d.minute, d.second, d.year,
                         d.month, d.mday, d.wday, d.yday);
    endfunction

    // Queue a prediction per input beat, compare each output beat
    always @(posedge i_clk) begin : watch
        cal_date_t got;
        cal_date_t want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                expected_dates.push_back(convert_unix_time(i_timestamp));
            end
            if (i_out_valid && !i_out_stall) begin
                got.valid_res = i_valid_res;
                got.second    = i_second;
                got.minute    = i_minute;
                got.hour      = i_hour;
                got.year      = i_year_since_1900;
                got.month     = i_month;
                got.mday      = i_day_of_month;
                got.wday      = i_weekday;
                got.yday      = i_day_of_year;
                if (expected_dates.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10) begin
                        $display("[%0t] unexpected beat: %s", $realtime, date_text(got));
                    end
                end else begin
                    want = expected_dates.pop_front();
                    if (got.valid_res !== want.valid_res || got.second !== want.second ||
                        got.minute !== want.minute || got.hour !== want.hour ||
                        got.year !== want.year || got.month !== want.month ||
                        got.mday !== want.mday || got.wday !== want.wday ||
                        got.yday !== want.yday) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10) begin
                            $display("[%0t] mismatch: expected %s", $realtime,
                                     date_text(want));
                            $display("[%0t]           actual   %s", $realtime,
                                     date_text(got));
                        end
                    end
                end
            end
        end
        pending_count <= expected_dates.size();
    end

endmodule

// ===== dv/tb_unix_time_to_calendar_date_unit.sv =====
`timescale 1ns / 1ps

module tb_unix_time_to_calendar_date_unit;
    import ucd_pkg::*;

    localparam int RANDOM_BEATS = 1800;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 100;
    localparam int DRAIN_CYCLES = 20;

    // Corner timestamps: zero, unit boundaries, leap days, year ends, top of range
    localparam logic [31:0] CORNER_STAMPS [25] = '{
        32'd0,          32'd1,          32'd59,         32'd60,
        32'd3599,       32'd3600,       32'd86399,      32'd86400,
        32'd68169600,   32'd94608000,   32'd94694400,   32'd951782400,
        32'd951868800,  32'd978307199,  32'd978307200,  32'd1704067200,
        32'd1709164800, 32'd1735603200, 32'd4107456000, 32'd4107542400,
        32'h7FFFFFFF,   32'h80000000,   32'hAAAAAAAA,   32'h55555555,
        32'hFFFFFFFF
    };

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_stall;
    logic [TS_W-1:0] i_timestamp;
    logic            o_valid;
    logic            i_stall;
    logic            o_valid_res;
    logic [5:0]      o_second;
    logic [5:0]      o_minute;
    logic [4:0]      o_hour;
    logic [7:0]      o_year_since_1900;
    logic [3:0]      o_month;
    logic [4:0]      o_day_of_month;
    logic [2:0]      o_weekday;
    logic [8:0]      o_day_of_year;

    int   err_count;
    int   pending;
    int   cycle_count = 0;
    logic tx_gapless  = 1'b0;
    logic rx_gapless  = 1'b0;
    logic hold_req    = 1'b0;

    unix_time_to_calendar_date_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_timestamp       (i_timestamp),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_valid_res       (o_valid_res),
        .o_second          (o_second),
        .o_minute          (o_minute),
        .o_hour            (o_hour),
        .o_year_since_1900 (o_year_since_1900),
        .o_month           (o_month),
        .o_day_of_month    (o_day_of_month),
        .o_weekday         (o_weekday),
        .o_day_of_year     (o_day_of_year)
    );

    ucd_checker date_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_timestamp       (i_timestamp),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_valid_res       (o_valid_res),
        .i_second          (o_second),
        .i_minute          (o_minute),
        .i_hour            (o_hour),
        .i_year_since_1900 (o_year_since_1900),
        .i_month           (o_month),
        .i_day_of_month    (o_day_of_month),
        .i_weekday         (o_weekday),
        .i_day_of_year     (o_day_of_year),
        .o_err_count       (err_count),
        .o_pending         (pending)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
    end
    always #6 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_unix_time_to_calendar_date_unit: FAIL");
            $finish;
        end
    end

    // Offer one timestamp beat after a random gap (none when tx_gapless); returns at its acceptance edge
    task automatic send_beat(input logic [31:0] stamp);
        int gap;
        gap = tx_gapless ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_timestamp <= stamp;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Stop offering and wait until every predicted result has been seen
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Receiver: random stall before each result unless rx_gapless, one long hold on request
    initial begin : receiver
        int hold;
        int taken;
        taken   = 0;
        i_stall = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                hold     = HOLD_CYCLES;
            end else begin
                hold = rx_gapless ? 0 : $urandom_range(0, 12);
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
            taken = taken + 1;
            if (taken % 100 == 0) begin
                rx_gapless = ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        longint unsigned yr;
        longint unsigned day_idx;
        longint unsigned stamp;
        int              kind;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_timestamp = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        foreach (CORNER_STAMPS[k]) begin
            send_beat(CORNER_STAMPS[k]);
        end
        wait_drained();

        // random timestamps, shaped toward calendar edges
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 100 == 0) begin
                tx_gapless = ($urandom_range(0, 3) == 0);
            end
            // back-to-back beats against a long output hold
            if (n >= 600 && n < 700) begin
                tx_gapless = 1'b1;
            end
            if (n == 600) begin
                hold_req = 1'b1;
            end
            // let the pipe run dry once mid-run
            if (n == 1000) begin
                wait_drained();
            end
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: begin
                    stamp = $urandom;
                end
                4, 5: begin
                    // around midnight of a random day
                    day_idx = $urandom_range(0, 49710);
                    case ($urandom_range(0, 3))
                        0:       stamp = day_idx * 86400;
                        1:       stamp = day_idx * 86400 + 86399;
                        2:       stamp = day_idx * 86400 + $urandom_range(0, 3);
                        default: stamp = day_idx * 86400 + $urandom_range(0, 86399);
                    endcase
                end
                6: begin
                    // zero or small values
                    stamp = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 200000);
                end
                7: begin
                    stamp = 64'hFFFF_FFFF - $urandom_range(0, 10000000);
                end
                default: begin
                    // near Jan 1, end of Feb, Mar 1 or Dec 31 of a random year
                    yr      = $urandom_range(1970, 2105);
                    day_idx = 365 * (yr - 1970) + (yr - 1969) / 4 - (yr - 1901) / 100
                              + (yr - 1601) / 400;
                    case ($urandom_range(0, 6))
                        0:       day_idx = day_idx;
                        1:       day_idx = day_idx + 58;
                        2:       day_idx = day_idx + 59;
                        3:       day_idx = day_idx + 60;
                        4:       day_idx = day_idx + 364;
                        5:       day_idx = day_idx + 365;
                        default: day_idx = day_idx + $urandom_range(0, 365);
                    endcase
                    stamp = day_idx * 86400 + $urandom_range(0, 86399);
                end
            endcase
            send_beat(32'(stamp));
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("tb_unix_time_to_calendar_date_unit: PASS");
        end else begin
            $display("tb_unix_time_to_calendar_date_unit: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/ucd_pkg.sv
design/ucd_time_split.sv
design/ucd_date_core.sv
design/ucd_day_count.sv
design/unix_time_to_calendar_date_unit.sv
dv/ucd_checker.sv
dv/tb_unix_time_to_calendar_date_unit.sv
